FILE: src/assert_macros.svh
// assertion macros shared by the correlation sum pair counter rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("csp assertion failed");

// expression must never be true outside reset
`define CSP_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("csp forbidden condition seen");

`endif

FILE: src/csp_pkg.sv
// types and constants for the correlation sum pair counter
// used by csp_ctrl, csp_dp and the top level, no dependencies
package csp_pkg;

  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int DIM_W    = 5;
  localparam int DLY_W    = 5;
  localparam int RADIUS_W = 40;
  localparam int PAIR_W   = 20;
  localparam int VCNT_W   = 11;
  localparam int SQ_W     = 32;
  localparam int PROD_W   = DIM_W + DLY_W;

  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};
  localparam logic [VCNT_W-1:0] VCNT_MAX = {VCNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [DIM_W-1:0]           embed_dim;
    logic [RADIUS_W-1:0]        radius_sq;
  } csp_in_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_count;
    logic [VCNT_W-1:0] vector_count;
    logic              too_few;
    logic              overflow_seen;
  } csp_out_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic query;
    logic setup;
    logic step;
    logic result;
  } csp_cmd_t;

  typedef struct packed {
    logic few;
    logic last_elem;
    logic last_pair;
    logic pipe_busy;
    logic out_full;
  } csp_stat_t;

endpackage

FILE: src/csp_ctrl.sv
// sequencer for the correlation sum pair counter
// depends on csp_pkg and assert_macros.svh
`include "assert_macros.svh"

module csp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [csp_pkg::KIND_W-1:0] in_kind_i,
  output logic                       in_stall_o,
  input  csp_pkg::csp_stat_t         stat_i,
  output csp_pkg::csp_cmd_t          cmd_o
);
  import csp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (kind_e'(in_kind_i))
            KIND_LOAD: begin
              cmd_o.load = 1'b1;
            end
            KIND_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            KIND_QUERY: begin
              cmd_o.query = 1'b1;
              state_d     = ST_SETUP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.few ? ST_RESULT : ST_RUN;
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (stat_i.last_elem && stat_i.last_pair) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!stat_i.out_full) begin
          cmd_o.result = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `CSP_ASSERT(a_drain_done, state_q == ST_DRAIN && !stat_i.pipe_busy |=> state_q == ST_RESULT)
  `CSP_ASSERT(a_run_entry, state_q == ST_RUN && $past(state_q) != ST_RUN |-> $past(state_q) == ST_SETUP)

endmodule

FILE: src/csp_dp.sv
// datapath of the correlation sum pair counter: sample store, pair walk,
// distance pipeline and output register; depends on csp_pkg, assert_macros.svh
`include "assert_macros.svh"

module csp_dp #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_DIM     = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  csp_pkg::csp_cmd_t         cmd_i,
  output csp_pkg::csp_stat_t        stat_o,
  input  csp_pkg::csp_in_t          in_data_i,
  input  logic                      cfg_we_i,
  input  logic [csp_pkg::DLY_W-1:0] cfg_wdata_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output csp_pkg::csp_out_t         out_data_o
);
  import csp_pkg::*;

  localparam int AW      = $clog2(MAX_SAMPLES);
  localparam int CW      = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_W   = SQ_W + $clog2(MAX_DIM + 1);
  localparam int CMP_W   = (ACC_W > RADIUS_W) ? ACC_W : RADIUS_W;
  localparam int MW      = ((CW > VCNT_W) ? CW : VCNT_W) + 2;
  localparam int DIM_CAP = (MAX_DIM < 31) ? MAX_DIM : 31;
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int FULL_W  = 2 * DIFF_W;

  // configuration and sample bookkeeping
  logic [DLY_W-1:0] delay_q;
  logic [CW-1:0]    loaded_q;
  logic             dropped_q;
  logic             wr_en;

  // query operands
  logic [DIM_W-1:0]    dim_q, dim_d;
  logic [DLY_W-1:0]    dly_q;
  logic [RADIUS_W-1:0] rsq_q;
  logic [PROD_W-1:0]   prod;
  logic signed [MW-1:0] m_s;
  logic                few;
  logic [VCNT_W-1:0]   vcount;

  // pair walk
  logic [AW-1:0]    kb_q, hb_q, p1_q, p2_q, lo_q, dly_a;
  logic [DIM_W-1:0] w_q;
  logic             last_elem, last_h, last_pair;

  // distance pipeline
  logic signed [SAMPLE_W-1:0] mem_q [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] rd1_q, rd2_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [FULL_W-1:0]   prod_full;
  logic [SQ_W-1:0]            sq_q;
  logic [ACC_W-1:0]           acc_q;
  logic                       v1_q, v2_q, v3_q, hv_q;
  logic                       first1_q, first2_q, first3_q;
  logic                       last1_q, last2_q, last3_q;
  logic [PAIR_W-1:0]          pairs_q;

  logic     out_valid_q;
  csp_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DLY_W'(1);
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  assign wr_en = cmd_i.load && (loaded_q < CW'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.restart) begin
      loaded_q  <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (wr_en) begin
        loaded_q <= loaded_q + CW'(1);
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[loaded_q[AW-1:0]] <= in_data_i.sample_value;
    end
    if (cmd_i.step) begin
      rd1_q <= mem_q[p1_q];
      rd2_q <= mem_q[p2_q];
    end
  end

  // query setup
  always_comb begin
    if (in_data_i.embed_dim == '0) begin
      dim_d = DIM_W'(1);
    end else if (in_data_i.embed_dim > DIM_W'(DIM_CAP)) begin
      dim_d = DIM_W'(DIM_CAP);
    end else begin
      dim_d = in_data_i.embed_dim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      dim_q <= dim_d;
      dly_q <= (delay_q == '0) ? DLY_W'(1) : delay_q;
      rsq_q <= in_data_i.radius_sq;
    end
  end

  assign prod = PROD_W'(dim_q) * PROD_W'(dly_q);
  assign m_s  = MW'(loaded_q) + MW'(1) - MW'(prod);
  assign few  = m_s < $signed(MW'(3));

  always_comb begin
    if (m_s <= $signed(MW'(0))) begin
      vcount = '0;
    end else if (m_s > $signed(MW'(VCNT_MAX))) begin
      vcount = VCNT_MAX;
    end else begin
      vcount = VCNT_W'(m_s);
    end
  end

  // pair walk: kb/hb point at the newest element of vectors k and h
  assign dly_a     = AW'(dly_q);
  assign last_elem = (w_q == dim_q - DIM_W'(1));
  assign last_h    = (hb_q == lo_q);
  assign last_pair = last_h && (kb_q == lo_q + AW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      lo_q <= AW'(prod - PROD_W'(1));
      kb_q <= AW'(loaded_q - CW'(1));
      hb_q <= AW'(loaded_q - CW'(2));
      p1_q <= AW'(loaded_q - CW'(1));
      p2_q <= AW'(loaded_q - CW'(2));
      w_q  <= '0;
    end else if (cmd_i.step) begin
      if (!last_elem) begin
        p1_q <= p1_q - dly_a;
        p2_q <= p2_q - dly_a;
        w_q  <= w_q + DIM_W'(1);
      end else begin
        w_q <= '0;
        if (last_h) begin
          kb_q <= kb_q - AW'(1);
          hb_q <= kb_q - AW'(2);
          p1_q <= kb_q - AW'(1);
          p2_q <= kb_q - AW'(2);
        end else begin
          hb_q <= hb_q - AW'(1);
          p1_q <= kb_q;
          p2_q <= hb_q - AW'(1);
        end
      end
    end
  end

  // distance pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      hv_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
      v2_q <= v1_q;
      v3_q <= v2_q;
      hv_q <= v3_q && last3_q;
    end
  end

  assign prod_full = FULL_W'(diff_q) * FULL_W'(diff_q);

  always_ff @(posedge clk_i) begin
    first1_q <= (w_q == '0);
    last1_q  <= last_elem;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    diff_q   <= DIFF_W'(rd1_q) - DIFF_W'(rd2_q);
    sq_q     <= prod_full[SQ_W-1:0];
    if (v3_q) begin
      acc_q <= first3_q ? ACC_W'(sq_q) : acc_q + ACC_W'(sq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q <= '0;
    end else if (cmd_i.query) begin
      pairs_q <= '0;
    end else if (hv_q && (CMP_W'(acc_q) <= CMP_W'(rsq_q))) begin
      pairs_q <= (pairs_q >= PAIR_MAX - PAIR_W'(1)) ? PAIR_MAX : pairs_q + PAIR_W'(2);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      out_q.pair_count    <= pairs_q;
      out_q.vector_count  <= vcount;
      out_q.too_few       <= few;
      out_q.overflow_seen <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.few       = few;
  assign stat_o.last_elem = last_elem;
  assign stat_o.last_pair = last_pair;
  assign stat_o.pipe_busy = v1_q || v2_q || v3_q || hv_q;
  assign stat_o.out_full  = out_valid_q && out_stall_i;

  `CSP_ASSERT(a_addr_order, cmd_i.step |-> p2_q < p1_q)
  `CSP_ASSERT_NEVER(a_fill_range, loaded_q > CW'(MAX_SAMPLES))
  `CSP_ASSERT(a_pair_even, !pairs_q[0] || pairs_q == PAIR_MAX)

endmodule

FILE: src/correlation_sum_pair_counter.sv
// correlation sum pair counter, top level
// instantiates csp_ctrl and csp_dp; depends on csp_pkg
//
// input channel in_valid_i / in_stall_o carries csp_in_t items: a load
// appends one sample to the store (dropped and flagged once the store is
// full), a restart empties it, a query counts ordered pairs of delay
// vectors within the squared radius. only a query yields a result, on the
// out_valid_o / out_stall_i channel.
// loads, restarts and unused kinds are taken without leaving idle. a query
// runs the pair walk, which issues one vector element a cycle through a
// two-port read of the sample store; then a four-stage subtract, square,
// accumulate and compare pipe drains. a query with too few vectors goes
// from setup straight to the result.
// the result sits in an output register; while it waits for a transfer,
// loads and restarts are still taken and a new query runs but holds its
// result back until the register frees up.
// reset clears the sample count, the dropped flag and the output valid and
// sets delay_step to 1; store contents are not cleared and need no sweep.
// cfg_we_i writes delay_step; write it only while no query is in flight.

module correlation_sum_pair_counter #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_DIM     = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  csp_pkg::csp_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output csp_pkg::csp_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [csp_pkg::DLY_W-1:0] cfg_wdata_i
);
  import csp_pkg::*;

  csp_cmd_t  cmd;
  csp_stat_t stat;

  csp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csp_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_DIM     (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
